/* rtl/task_runtime_share_table_macros.svh */
// Assertion macros shared by the task runtime share table RTL
`ifndef TASK_RUNTIME_SHARE_TABLE_MACROS_SVH
`define TASK_RUNTIME_SHARE_TABLE_MACROS_SVH

// Same-cycle implication, checked only out of reset
`define TRST_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trst: implication check failed");

// Next-cycle implication, checked only out of reset
`define TRST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trst: next-cycle check failed");

`endif

/* rtl/trst_pkg.sv */
// Shared constants and controller/datapath interface types for the share table
package trst_pkg;

  localparam int NUM_SLOTS = 24;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int TASK_W    = 16;
  localparam int CNT_W     = 32;
  localparam int OUT_IDX_W = 5;
  localparam int PCT_W     = 7;
  localparam int MODE_W    = 2;

  // delta*100 + pass/2 fits in 39 bits
  localparam int NUM_W     = 39;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;

  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END    = 2'd2;

  typedef struct packed {
    logic start_pass;
    logic end_pass;
    logic load;
    logic scan_step;
    logic finish;
    logic mul;
    logic div_step;
    logic push;
  } trst_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_last;
    logic out_busy;
  } trst_sts_t;

endpackage

/* rtl/trst_ctrl.sv */
// Sequencer for the share table: scan, finish, multiply, divide, hand off
module trst_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [trst_pkg::MODE_W-1:0] in_mode,
  output logic                       in_stall,
  input  trst_pkg::trst_sts_t        sts,
  output trst_pkg::trst_cmd_t        cmd
);
  import trst_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_FIN  = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_START: cmd.start_pass = 1'b1;
            MODE_END:   cmd.end_pass   = 1'b1;
            MODE_SAMPLE: begin
              cmd.load  = 1'b1;
              state_nxt = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/trst_dp.sv */
// Slot table, pass bookkeeping, serial slot search, divider and output register
module trst_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trst_pkg::trst_cmd_t           cmd,
  output trst_pkg::trst_sts_t           sts,
  input  logic [trst_pkg::TASK_W-1:0]    in_task_id,
  input  logic [trst_pkg::CNT_W-1:0]     in_run_counter,
  input  logic [trst_pkg::CNT_W-1:0]     in_sys_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [trst_pkg::OUT_IDX_W-1:0] out_slot_index,
  output logic                          out_tracked,
  output logic [trst_pkg::CNT_W-1:0]     out_run_delta,
  output logic [trst_pkg::PCT_W-1:0]     out_share_percent,
  output logic                          out_percent_valid,
  output logic                          out_below_one
);
  import trst_pkg::*;

  // slot table and pass state
  logic [TASK_W-1:0]    slot_task_r    [NUM_SLOTS];
  logic [CNT_W-1:0]     slot_counter_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] seen_r;
  logic [CNT_W-1:0]     prev_total_r;
  logic [CNT_W-1:0]     pass_delta_r;

  // current sample
  logic [TASK_W-1:0]    id_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [SLOT_W-1:0]    scan_r;
  logic                 match_found_r, empty_found_r;
  logic [SLOT_W-1:0]    match_idx_r, empty_idx_r;
  logic [SLOT_W-1:0]    slot_r;
  logic                 tracked_r;
  logic [CNT_W-1:0]     delta_r;
  logic [NUM_W-1:0]     num_r;
  logic [CNT_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // output register
  logic                 out_valid_r;
  logic [OUT_IDX_W-1:0] out_slot_r;
  logic                 out_tracked_r;
  logic [CNT_W-1:0]     out_delta_r;
  logic [PCT_W-1:0]     out_pct_r;
  logic                 out_pvalid_r;
  logic                 out_below_r;

  logic              have;
  logic [SLOT_W-1:0] fin_slot;
  logic [CNT_W-1:0]  fin_delta;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              rem_ge;
  logic              pass_nz;
  logic [PCT_W-1:0]  pct_sat;
  logic [NUM_W-1:0]  num_mul;

  assign have     = match_found_r | empty_found_r;
  assign fin_slot = match_found_r ? match_idx_r : empty_idx_r;
  assign fin_delta = match_found_r ? (cnt_r - slot_counter_r[fin_slot]) : cnt_r;

  assign num_mul = NUM_W'(delta_r) * NUM_W'(PCT_SCALE) + NUM_W'(pass_delta_r >> 1);

  // remainder stays below the divisor, so it fits in CNT_W bits
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, pass_delta_r});
  assign rem_sub = rem_sh - {1'b0, pass_delta_r};

  assign pass_nz = (pass_delta_r != '0);
  assign pct_sat = !pass_nz ? '0 :
                   (num_r > NUM_W'(PCT_MAX)) ? PCT_MAX : num_r[PCT_W-1:0];

  assign sts.scan_last = (scan_r == SLOT_W'(NUM_SLOTS - 1));
  assign sts.div_last  = (div_cnt_r == DIV_CNT_W'(NUM_W - 1));
  assign sts.out_busy  = out_valid_r & out_stall;

  // table and pass state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_task_r[i]    <= '0;
        slot_counter_r[i] <= '0;
      end
      seen_r       <= '0;
      prev_total_r <= '0;
      pass_delta_r <= '0;
    end else begin
      if (cmd.start_pass) begin
        pass_delta_r <= in_sys_time - prev_total_r;
        prev_total_r <= in_sys_time;
        seen_r       <= '0;
      end
      if (cmd.end_pass) begin
        // drop every slot not seen this pass
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!seen_r[i]) begin
            slot_task_r[i]    <= '0;
            slot_counter_r[i] <= '0;
          end
        end
      end
      if (cmd.finish && have) begin
        slot_counter_r[fin_slot] <= cnt_r;
        if (!match_found_r) slot_task_r[fin_slot] <= id_r;
        seen_r[fin_slot] <= 1'b1;
      end
    end
  end

  // search and arithmetic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r        <= '0;
      match_found_r <= 1'b0;
      empty_found_r <= 1'b0;
      div_cnt_r     <= '0;
    end else begin
      if (cmd.load) begin
        scan_r        <= '0;
        match_found_r <= 1'b0;
        empty_found_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        scan_r <= scan_r + 1'b1;
        if (id_r != '0) begin
          if (!match_found_r && slot_task_r[scan_r] == id_r) begin
            match_found_r <= 1'b1;
          end
          if (!empty_found_r && slot_task_r[scan_r] == '0) begin
            empty_found_r <= 1'b1;
          end
        end
      end
      if (cmd.mul) div_cnt_r <= '0;
      if (cmd.div_step) div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r  <= in_task_id;
      cnt_r <= in_run_counter;
    end
    if (cmd.scan_step) begin
      if (!match_found_r) match_idx_r <= scan_r;
      if (!empty_found_r) empty_idx_r <= scan_r;
    end
    if (cmd.finish) begin
      slot_r    <= have ? fin_slot : '0;
      tracked_r <= have;
      delta_r   <= fin_delta;
    end
    if (cmd.mul) begin
      num_r <= num_mul;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      num_r <= {num_r[NUM_W-2:0], rem_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_slot_r    <= OUT_IDX_W'(slot_r);
      out_tracked_r <= tracked_r;
      out_delta_r   <= delta_r;
      out_pct_r     <= pct_sat;
      out_pvalid_r  <= pass_nz;
      out_below_r   <= pass_nz && (pct_sat == '0) && (delta_r != '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_slot_index    = out_slot_r;
  assign out_tracked       = out_tracked_r;
  assign out_run_delta     = out_delta_r;
  assign out_share_percent = out_pct_r;
  assign out_percent_valid = out_pvalid_r;
  assign out_below_one     = out_below_r;

endmodule

/* rtl/task_runtime_share_table.sv */
// Top level of the task runtime share table: controller plus datapath
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | mode, task_id, run_counter, sys_time
//   out_    | output    | out_valid / out_stall | slot_index, tracked, run_delta,
//           |           |                      | share_percent, percent_valid, below_one
//
// Start and end of pass are handled without leaving the idle state. A task
// sample passes through the accepting step, one step per slot in the serial
// table search, a finish and a multiply step, one step per quotient bit in
// the restoring divider, and the handoff.
// in_stall is high while a sample is in work; a stalled output holds the
// sequencer in its handoff step, but one finished result may wait in the
// output register while the next sample runs. Reset is synchronous, active
// low, and empties all slots and the pass state.
module task_runtime_share_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_task_id,
  input  logic [31:0] in_run_counter,
  input  logic [31:0] in_sys_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_slot_index,
  output logic        out_tracked,
  output logic [31:0] out_run_delta,
  output logic [6:0]  out_share_percent,
  output logic        out_percent_valid,
  output logic        out_below_one
);
  import trst_pkg::*;

  `include "task_runtime_share_table_macros.svh"

  trst_cmd_t cmd;
  trst_sts_t sts;

  trst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  trst_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_task_id        (in_task_id),
    .in_run_counter    (in_run_counter),
    .in_sys_time       (in_sys_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_slot_index    (out_slot_index),
    .out_tracked       (out_tracked),
    .out_run_delta     (out_run_delta),
    .out_share_percent (out_share_percent),
    .out_percent_valid (out_percent_valid),
    .out_below_one     (out_below_one)
  );

  `TRST_ASSERT_IMPL(a_push_free, cmd.push, !sts.out_busy)
  `TRST_ASSERT_NEXT(a_push_shows, cmd.push, out_valid)
  `TRST_ASSERT_NEXT(a_sample_busy, in_valid && !in_stall && in_mode == MODE_SAMPLE, in_stall)
  `TRST_ASSERT_IMPL(a_untracked_idx, out_valid && !out_tracked, out_slot_index == '0)

endmodule

/* tb/share_checker.sv */
// Checker for the task runtime share table: predicts each sample result and compares it
`timescale 1ns / 100ps

module share_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_task_id,
  input  logic [31:0] in_run_counter,
  input  logic [31:0] in_sys_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [4:0]  out_slot_index,
  input  logic        out_tracked,
  input  logic [31:0] out_run_delta,
  input  logic [6:0]  out_share_percent,
  input  logic        out_percent_valid,
  input  logic        out_below_one,
  output int          errors,
  output int          pending
);
  import trst_pkg::*;

  typedef struct packed {
    logic [4:0]  slot;
    logic        tracked;
    logic [31:0] delta;
    logic [6:0]  pct;
    logic        pct_ok;
    logic        below;
  } share_result_t;

  logic [15:0]          slot_owner [NUM_SLOTS];
  logic [31:0]          slot_last  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] seen;
  logic [31:0]          last_total;
  logic [31:0]          pass_time;
  share_result_t        share_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("share mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // Look up or claim a slot, update it and work out the share of the pass time
  function automatic share_result_t sample_share(input logic [15:0] id,
                                                 input logic [31:0] cnt);
    share_result_t r;
    int hit;
    logic [63:0] q;
    r = '0;
    hit = -1;
    r.delta = cnt;
    if (id != 16'd0) begin
      for (int k = 0; k < NUM_SLOTS; k++)
        if (hit < 0 && slot_owner[k] == id) hit = k;
      if (hit >= 0) begin
        r.delta = cnt - slot_last[hit];
        slot_last[hit] = cnt;
      end else begin
        for (int k = 0; k < NUM_SLOTS; k++)
          if (hit < 0 && slot_owner[k] == 16'd0) hit = k;
        if (hit >= 0) begin
          slot_owner[hit] = id;
          slot_last[hit] = cnt;
        end
      end
      if (hit >= 0) begin
        seen[hit] = 1'b1;
        r.tracked = 1'b1;
        r.slot = 5'(hit);
      end
    end
    if (pass_time != 32'd0) begin
      r.pct_ok = 1'b1;
      q = (64'(r.delta) * 64'd100 + 64'(pass_time >> 1)) / 64'(pass_time);
      if (q > 64'd100) q = 64'd100;
      r.pct = q[6:0];
      r.below = (q == 64'd0) && (r.delta != 32'd0);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    share_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_owner[k] = '0;
        slot_last[k] = '0;
      end
      seen = '0;
      last_total = '0;
      pass_time = '0;
      share_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (share_due.size() == 0) begin
          report_mismatch("result beat with nothing due", out_run_delta, 32'd0);
        end else begin
          want = share_due.pop_front();
          if (out_slot_index !== want.slot)
            report_mismatch("slot_index", 32'(out_slot_index), 32'(want.slot));
          if (out_tracked !== want.tracked)
            report_mismatch("tracked", 32'(out_tracked), 32'(want.tracked));
          if (out_run_delta !== want.delta)
            report_mismatch("run_delta", out_run_delta, want.delta);
          if (out_share_percent !== want.pct)
            report_mismatch("share_percent", 32'(out_share_percent), 32'(want.pct));
          if (out_percent_valid !== want.pct_ok)
            report_mismatch("percent_valid", 32'(out_percent_valid), 32'(want.pct_ok));
          if (out_below_one !== want.below)
            report_mismatch("below_one", 32'(out_below_one), 32'(want.below));
        end
      end
      if (in_valid && !in_stall) begin
        case (in_mode)
          MODE_START: begin
            pass_time = in_sys_time - last_total;
            last_total = in_sys_time;
            seen = '0;
          end
          MODE_SAMPLE: share_due.push_back(sample_share(in_task_id, in_run_counter));
          MODE_END: begin
            // drop every task that did not report during this pass
            for (int k = 0; k < NUM_SLOTS; k++)
              if (!seen[k]) begin
                slot_owner[k] = '0;
                slot_last[k] = '0;
              end
          end
          default: ;
        endcase
      end
    end
    pending <= share_due.size();
  end

endmodule

/* tb/tb_top.sv */
// Top of the share table testbench: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_top;
  import trst_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET  = 1700;
  localparam int CALM_FROM    = 1500;
  localparam int STUCK_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 80;
  localparam int POOL         = 32;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [15:0] in_task_id;
  logic [31:0] in_run_counter;
  logic [31:0] in_sys_time;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_slot_index;
  logic        out_tracked;
  logic [31:0] out_run_delta;
  logic [6:0]  out_share_percent;
  logic        out_percent_valid;
  logic        out_below_one;

  int          errors;
  int          pending;
  int          items_sent;
  int          stuck;
  bit          calm;
  logic [31:0] total_clock;
  logic [15:0] pool_id  [POOL];
  logic [31:0] pool_cnt [POOL];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task_runtime_share_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_task_id(in_task_id),
    .in_run_counter(in_run_counter), .in_sys_time(in_sys_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_slot_index(out_slot_index), .out_tracked(out_tracked),
    .out_run_delta(out_run_delta), .out_share_percent(out_share_percent),
    .out_percent_valid(out_percent_valid), .out_below_one(out_below_one)
  );

  share_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_task_id(in_task_id),
    .in_run_counter(in_run_counter), .in_sys_time(in_sys_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_slot_index(out_slot_index), .out_tracked(out_tracked),
    .out_run_delta(out_run_delta), .out_share_percent(out_share_percent),
    .out_percent_valid(out_percent_valid), .out_below_one(out_below_one),
    .errors(errors), .pending(pending)
  );

  // Present one beat at a falling edge and hold it until accepted
  task automatic send_item(input logic [1:0] mode, input logic [15:0] id,
                           input logic [31:0] cnt, input logic [31:0] tot);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_task_id     <= id;
    in_run_counter <= cnt;
    in_sys_time    <= tot;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // One logging pass: start, samples of pooled tasks with some noise, usually an end
  task automatic run_pass();
    logic [31:0] step;
    logic [31:0] adv;
    int n;
    int width;
    int k;
    case ($urandom_range(0, 9))
      0:       step = 32'd0;
      1, 2:    step = $urandom_range(1, 1000);
      3:       step = $urandom;
      default: step = $urandom_range(1000, 5000000);
    endcase
    total_clock += step;
    send_item(MODE_START, 16'($urandom), $urandom, total_clock);
    if ($urandom_range(0, 3) == 0) pool_id[$urandom_range(0, POOL-1)] = 16'($urandom_range(1, 65535));
    width = ($urandom_range(0, 1) == 0) ? POOL : $urandom_range(2, 24);
    n = $urandom_range(1, 36);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(2'($urandom_range(0, 3)),
                  ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                  $urandom, $urandom);
      end else begin
        k = $urandom_range(0, width - 1);
        case ($urandom_range(0, 7))
          0:       adv = $urandom;
          1:       adv = step + $urandom_range(0, 1000);
          2:       adv = 32'd0;
          default: adv = (step == 32'd0) ? $urandom_range(0, 5000) : $urandom_range(0, step);
        endcase
        pool_cnt[k] += adv;
        send_item(MODE_SAMPLE, pool_id[k], pool_cnt[k], $urandom);
      end
    end
    if ($urandom_range(0, 5) != 0) send_item(MODE_END, 16'($urandom), $urandom, $urandom);
  endtask

  // Result side backpressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_START;
    in_task_id     = '0;
    in_run_counter = '0;
    in_sys_time    = '0;
    calm           = 1'b0;
    items_sent     = 0;
    total_clock    = '0;
    for (int k = 0; k < POOL; k++) begin
      pool_id[k]  = 16'($urandom_range(1, 65535));
      pool_cnt[k] = $urandom;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no pass time yet, id zero, ignored mode
    send_item(MODE_SAMPLE, 16'd5, 32'h1234_5678, 32'd0);
    send_item(MODE_SAMPLE, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_START, 16'd0, 32'd0, 32'd0);
    send_item(MODE_SAMPLE, 16'd5, 32'h1234_5678, 32'd0);
    // pass of 1000: rounding, below one percent, saturation, counter wrap
    send_item(MODE_START, 16'hFFFF, 32'hFFFF_FFFF, 32'd1000);
    send_item(MODE_SAMPLE, 16'd5, 32'h1234_5682, 32'd0);
    send_item(MODE_SAMPLE, 16'd5, 32'h1234_5686, 32'd0);
    send_item(MODE_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    send_item(MODE_SAMPLE, 16'hFFFF, 32'h0000_0009, 32'd0);
    send_item(MODE_SAMPLE, 16'd7, 32'd0, 32'd0);
    send_item(MODE_SAMPLE, 16'd0, 32'd0, 32'd0);
    send_item(MODE_END, 16'd0, 32'd0, 32'd0);
    send_item(MODE_END, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // total at its top, then wrapping to a pass of one
    send_item(MODE_START, 16'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(MODE_SAMPLE, 16'hFFFF, 32'h8000_0009, 32'd0);
    send_item(MODE_START, 16'd0, 32'd0, 32'd0);
    send_item(MODE_SAMPLE, 16'd7, 32'd1, 32'd0);
    send_item(MODE_SAMPLE, 16'd3, 32'h0000_FFFF, 32'd0);
    send_item(MODE_END, 16'd0, 32'd0, 32'd0);
    send_item(MODE_SAMPLE, 16'd5, 32'd77, 32'd0);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_FROM) calm = 1'b1;
      run_pass();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/trst_pkg.sv
rtl/trst_ctrl.sv
rtl/trst_dp.sv
rtl/task_runtime_share_table.sv
tb/share_checker.sv
tb/tb_top.sv
